>>> rtl/dpts_pkg.sv
`timescale 1ns / 1ps

package dpts_pkg;

    // fixed sizes of the scanner
    localparam int OFFSET_BITS = 24;
    localparam int OFF_W       = OFFSET_BITS + 1;
    localparam int MAX_PERIODS = 16;
    localparam int HEAD_BYTES  = 256;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int SHORT_LEN   = 8;

    localparam logic [OFF_W-1:0] OFF_CAP  = {OFF_W{1'b1}};
    localparam logic [OFF_W-1:0] HEAD_OFF = OFF_W'(HEAD_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PERIODS);
    localparam logic [OFF_W-1:0] SHORT_OFF = OFF_W'(SHORT_LEN - 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // stream packing
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 72;

    // character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [3:0] URN_LEN     = 4'd13;
    localparam logic [2:0] MPD_LEN     = 3'd4;
    localparam logic [2:0] PERIOD_LEN  = 3'd7;
    localparam logic [2:0] ADBREAK_LEN = 3'd7;
    localparam logic [2:0] CARD_LEN    = 3'd4;

    // one queue entry: an optional period record and an optional summary
    typedef struct packed {
        logic                    rec_valid;
        logic [IDX_W-1:0]        rec_index;
        logic [OFFSET_BITS-1:0]  rec_start;
        logic [OFF_W-1:0]        rec_end;
        logic                    rec_ad;
        logic                    sum_valid;
        logic                    sum_looks;
        logic [CNT_W-1:0]        sum_periods;
        logic [CNT_W-1:0]        sum_ads;
        logic signed [CNT_W-1:0] sum_first_ad;
    } scan_event_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    // "urn:mpeg:dash"
    function automatic logic [7:0] urn_char(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:  r = "u";
            4'd1:  r = "r";
            4'd2:  r = "n";
            4'd3:  r = ":";
            4'd4:  r = "m";
            4'd5:  r = "p";
            4'd6:  r = "e";
            4'd7:  r = "g";
            4'd8:  r = ":";
            4'd9:  r = "d";
            4'd10: r = "a";
            4'd11: r = "s";
            4'd12: r = "h";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "<MPD"
    function automatic logic [7:0] mpd_char(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = "<";
            2'd1: r = "M";
            2'd2: r = "P";
            default: r = "D";
        endcase
        return r;
    endfunction

    // "<Period"
    function automatic logic [7:0] period_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = "<";
            3'd1: r = "P";
            3'd2: r = "e";
            3'd3: r = "r";
            3'd4: r = "i";
            3'd5: r = "o";
            3'd6: r = "d";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "Adbreak"
    function automatic logic [7:0] adbreak_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = "A";
            3'd1: r = "d";
            3'd2: r = "b";
            3'd3: r = "r";
            3'd4: r = "e";
            3'd5: r = "a";
            3'd6: r = "k";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "Card"
    function automatic logic [7:0] card_char(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = "C";
            2'd1: r = "a";
            2'd2: r = "r";
            default: r = "d";
        endcase
        return r;
    endfunction

endpackage

>>> rtl/dpts_front.sv
`timescale 1ns / 1ps

module dpts_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dpts_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    input  logic                        queue_full,
    output logic                        push,
    output dpts_pkg::scan_event_t       push_event
);
    import dpts_pkg::*;

    // anchored signature matcher at the first non-blank byte
    typedef enum logic [2:0] {
        ANC_IDLE, ANC_LT, ANC_QUEST, ANC_X, ANC_XM, ANC_M, ANC_MP, ANC_DEAD
    } anchor_t;

    logic [OFF_W-1:0]       off_reg, off_next;
    logic [2:0]             prefix_reg, prefix_next;
    logic                   inside_reg, inside_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [2:0]             adbreak_reg, adbreak_next;
    logic [1:0]             card_reg, card_next;
    logic                   has_ad_reg, has_ad_next;
    logic [CNT_W-1:0]       periods_reg, periods_next;
    logic [CNT_W-1:0]       ads_reg, ads_next;
    logic signed [CNT_W-1:0] first_ad_reg, first_ad_next;
    logic                   lead_done_reg, lead_done_next;
    anchor_t                anchor_reg, anchor_next;
    logic [3:0]             urn_reg, urn_next;
    logic [1:0]             mpd_reg, mpd_next;
    logic                   seen_reg, seen_next;

    logic                   accept;
    logic [7:0]             c;
    logic                   in_head;
    logic [3:0]             urn_t;
    logic [2:0]             mpd_t;
    logic [2:0]             adb_t;
    logic [2:0]             card_t;
    anchor_t                anc_from;
    logic                   anc_run;
    logic                   close_now;
    logic                   close_ad;
    scan_event_t            ev;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata[7:0];
    assign in_head  = off_reg < HEAD_OFF;

    always_comb begin
        off_next       = (off_reg != OFF_CAP) ? off_reg + 1'b1 : off_reg;
        prefix_next    = prefix_reg;
        inside_next    = inside_reg;
        start_next     = start_reg;
        adbreak_next   = adbreak_reg;
        card_next      = card_reg;
        has_ad_next    = has_ad_reg;
        periods_next   = periods_reg;
        ads_next       = ads_reg;
        first_ad_next  = first_ad_reg;
        lead_done_next = lead_done_reg;
        anchor_next    = anchor_reg;
        urn_next       = urn_reg;
        mpd_next       = mpd_reg;
        seen_next      = seen_reg;
        close_now      = 1'b0;
        close_ad       = 1'b0;
        urn_t          = '0;
        mpd_t          = '0;
        adb_t          = '0;
        card_t         = '0;
        anc_from       = anchor_reg;
        anc_run        = 1'b0;

        // signature within the head of the buffer
        if (in_head) begin
            urn_t = (c == urn_char(urn_reg)) ? urn_reg + 4'd1 :
                    ((c == urn_char(4'd0)) ? 4'd1 : 4'd0);
            if (urn_t == URN_LEN) begin
                seen_next = 1'b1;
                urn_next  = '0;
            end else begin
                urn_next  = urn_t;
            end
            mpd_t = (c == mpd_char(mpd_reg)) ? {1'b0, mpd_reg} + 3'd1 :
                    ((c == mpd_char(2'd0)) ? 3'd1 : 3'd0);
            if (mpd_t == MPD_LEN) begin
                seen_next = 1'b1;
                mpd_next  = '0;
            end else begin
                mpd_next  = mpd_t[1:0];
            end
        end

        // anchored signature after leading blanks
        if (!lead_done_reg) begin
            if (!(in_head && is_space(c))) begin
                lead_done_next = 1'b1;
                anc_from       = ANC_IDLE;
                anc_run        = 1'b1;
            end
        end else begin
            anc_run = 1'b1;
        end
        if (anc_run) begin
            anchor_next = ANC_DEAD;
            unique case (anc_from)
                ANC_IDLE:  if (c == "<") anchor_next = ANC_LT;
                ANC_LT: begin
                    if (c == CH_QUEST)  anchor_next = ANC_QUEST;
                    else if (c == "M")  anchor_next = ANC_M;
                end
                ANC_QUEST: if (c == "x") anchor_next = ANC_X;
                ANC_X:     if (c == "m") anchor_next = ANC_XM;
                ANC_XM:    if (c == "l") seen_next = 1'b1;
                ANC_M:     if (c == "P") anchor_next = ANC_MP;
                ANC_MP:    if (c == "D") seen_next = 1'b1;
                default:   anchor_next = ANC_DEAD;
            endcase
        end

        // period open tags
        if (inside_reg) begin
            if (c == CH_GT) begin
                close_now   = 1'b1;
                close_ad    = has_ad_reg;
                inside_next = 1'b0;
            end else begin
                adb_t = (c == adbreak_char(adbreak_reg)) ? adbreak_reg + 3'd1 :
                        ((c == adbreak_char(3'd0)) ? 3'd1 : 3'd0);
                if (adb_t == ADBREAK_LEN) begin
                    has_ad_next  = 1'b1;
                    adbreak_next = '0;
                end else begin
                    adbreak_next = adb_t;
                end
                card_t = (c == card_char(card_reg)) ? {1'b0, card_reg} + 3'd1 :
                         ((c == card_char(2'd0)) ? 3'd1 : 3'd0);
                if (card_t == CARD_LEN) begin
                    has_ad_next = 1'b1;
                    card_next   = '0;
                end else begin
                    card_next   = card_t[1:0];
                end
            end
        end else if (periods_reg < MAX_CNT) begin
            if (prefix_reg == PERIOD_LEN && (is_space(c) || c == CH_GT)) begin
                prefix_next = '0;
                if (c == CH_GT) begin
                    close_now = 1'b1;
                end else begin
                    inside_next  = 1'b1;
                    has_ad_next  = 1'b0;
                    adbreak_next = '0;
                    card_next    = '0;
                end
            end else if (prefix_reg != PERIOD_LEN && c == period_char(prefix_reg)) begin
                if (prefix_reg == 3'd0) start_next = off_reg[OFFSET_BITS-1:0];
                prefix_next = prefix_reg + 3'd1;
            end else if (c == CH_LT) begin
                start_next  = off_reg[OFFSET_BITS-1:0];
                prefix_next = 3'd1;
            end else begin
                prefix_next = '0;
            end
        end

        if (close_now) begin
            periods_next = periods_reg + 1'b1;
            if (close_ad) begin
                ads_next = ads_reg + 1'b1;
                if (first_ad_reg == '1) first_ad_next = periods_reg;
            end
        end

        // queue entry for this byte
        ev.rec_valid    = close_now;
        ev.rec_index    = periods_reg[IDX_W-1:0];
        ev.rec_start    = start_reg;
        ev.rec_end      = off_reg + 1'b1;
        ev.rec_ad       = close_ad;
        ev.sum_valid    = s_tlast;
        if (off_reg < SHORT_OFF) begin
            ev.sum_looks    = 1'b0;
            ev.sum_periods  = '0;
            ev.sum_ads      = '0;
            ev.sum_first_ad = '1;
        end else begin
            ev.sum_looks    = seen_next;
            ev.sum_periods  = periods_next;
            ev.sum_ads      = ads_next;
            ev.sum_first_ad = first_ad_next;
        end
    end

    assign push       = accept && (ev.rec_valid || ev.sum_valid);
    assign push_event = ev;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            off_reg       <= '0;
            prefix_reg    <= '0;
            inside_reg    <= 1'b0;
            start_reg     <= '0;
            adbreak_reg   <= '0;
            card_reg      <= '0;
            has_ad_reg    <= 1'b0;
            periods_reg   <= '0;
            ads_reg       <= '0;
            first_ad_reg  <= '1;
            lead_done_reg <= 1'b0;
            anchor_reg    <= ANC_IDLE;
            urn_reg       <= '0;
            mpd_reg       <= '0;
            seen_reg      <= 1'b0;
        end else if (accept) begin
            off_reg       <= off_next;
            prefix_reg    <= prefix_next;
            inside_reg    <= inside_next;
            start_reg     <= start_next;
            adbreak_reg   <= adbreak_next;
            card_reg      <= card_next;
            has_ad_reg    <= has_ad_next;
            periods_reg   <= periods_next;
            ads_reg       <= ads_next;
            first_ad_reg  <= first_ad_next;
            lead_done_reg <= lead_done_next;
            anchor_reg    <= anchor_next;
            urn_reg       <= urn_next;
            mpd_reg       <= mpd_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

>>> rtl/dpts_queue.sv
`timescale 1ns / 1ps

module dpts_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  dpts_pkg::scan_event_t push_event,
    input  logic                  pop,
    output dpts_pkg::scan_event_t head_event,
    output logic                  full,
    output logic                  empty
);
    import dpts_pkg::*;

    scan_event_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty      = count_reg == '0;
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_event = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_event;
    end

endmodule

>>> rtl/dpts_back.sv
`timescale 1ns / 1ps

module dpts_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dpts_pkg::scan_event_t         head_event,
    input  logic                          empty,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpts_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import dpts_pkg::*;

    logic                valid_reg, valid_next;
    logic                rec_done_reg, rec_done_next;
    logic [M_DATA_W-1:0] data_reg, data_next;
    logic                user_reg, user_next;
    logic                last_reg, last_next;
    logic                load;

    assign load = !valid_reg || m_tready;

    always_comb begin
        valid_next    = valid_reg;
        rec_done_next = rec_done_reg;
        data_next     = data_reg;
        user_next     = user_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                if (head_event.rec_valid && !rec_done_reg) begin
                    // record beat first, summary (if any) stays at the head
                    data_next = M_DATA_W'({
                        1'b0, {3*CNT_W{1'b0}}, head_event.rec_ad, head_event.rec_end,
                        head_event.rec_start, head_event.rec_index});
                    user_next = 1'b0;
                    last_next = 1'b0;
                    if (head_event.sum_valid) rec_done_next = 1'b1;
                    else                      pop = 1'b1;
                end else begin
                    data_next = M_DATA_W'({
                        head_event.sum_first_ad, head_event.sum_ads,
                        head_event.sum_periods, head_event.sum_looks, 1'b0,
                        {OFF_W{1'b0}}, {OFFSET_BITS{1'b0}}, {IDX_W{1'b0}}});
                    user_next     = 1'b1;
                    last_next     = 1'b1;
                    rec_done_next = 1'b0;
                    pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            rec_done_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rec_done_reg <= rec_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/dash_period_tag_scanner_top.sv
`timescale 1ns / 1ps

// channel  dir  tdata                       tuser        tlast
// s_       in   data_byte[7:0]              -            last_byte
// m_       out  period record / summary     record_kind  last_result
//
// one byte is taken every cycle; s_tready drops only while the queue is full;
// each byte is classified by the front in the cycle it arrives, and any record
// or summary it causes goes into a four-entry queue. the back sends one result
// beat per cycle from the queue head while m_tready is high; a byte that closes
// a tag and ends the buffer gives a record beat, then a summary beat. reset is
// synchronous and clears matchers, counters, queue pointers and output valid.

module dash_period_tag_scanner_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] period_index, [27:4] open_offset, [52:28] tag_end, [53] is_ad,
    // [54] manifest_flag, [59:55] period_total, [64:60] ad_total,
    // [69:65] first_ad_index, [71:70] zero
    output logic [71:0] m_tdata,
    // [0] record_kind
    output logic        m_tuser,
    output logic        m_tlast
);
    import dpts_pkg::*;

    scan_event_t push_event;
    scan_event_t head_event;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;

    // front: byte matchers and per-buffer counters
    dpts_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_event (push_event)
    );

    // decoupling queue
    dpts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .head_event (head_event),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    // back: splits each entry into beats behind an output register
    dpts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_event (head_event),
        .empty      (queue_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // an entry is never written into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && queue_full))
        else $error("queue written while full");

    // only the summary beat closes a buffer
    a_last_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("tlast and record kind disagree");

    // summary counts stay consistent
    a_summary_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[64:60] <= m_tdata[59:55]) && (m_tdata[59:55] <= MAX_CNT))
        else $error("summary counts out of range");

    // a popped entry always leaves a beat on the output
    a_pop_when_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid)
        else $error("entry popped without a beat");

endmodule
